[rtl/svpwm_pkg.sv]
`timescale 1ns / 1ps
package svpwm_pkg;

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int OFFSET_W   = 18;
  localparam int STEP_W     = 24;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 17;
  localparam int CODE_W     = 3;
  localparam int DEG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Internal widths
  localparam int ANGLE_W = 25;
  localparam int TRIG_W  = 17;
  localparam int IDX_W   = 7;

  localparam int SINE_ENTRIES = 91;

  // Q16 degrees in one electrical turn, and the largest step below it
  localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 * 65536);
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(360 * 65536 - 1);

  localparam logic [TRIG_W-1:0] Q16_ONE = TRIG_W'(65536);

  // 1/sqrt(3) and 2/sqrt(3) in Q16
  localparam logic [15:0] K_HALF_INV_SQRT3 = 16'd37840;
  localparam logic [16:0] K_TWO_INV_SQRT3  = 17'd75673;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_GAIN   = 2'd0,
    CFG_MOD_OFFSET = 2'd1,
    CFG_ANGLE_STEP = 2'd2,
    CFG_PWM_PERIOD = 2'd3
  } cfg_reg_t;

  // Sector code: {Vb negative, Va negative, b negative}
  typedef enum logic [CODE_W-1:0] {
    SEC_Q1_BPOS = 3'd0,
    SEC_Q1_BNEG = 3'd1,
    SEC_Q2_BPOS = 3'd2,
    SEC_Q2_BNEG = 3'd3,
    SEC_Q4_BPOS = 3'd4,
    SEC_Q4_BNEG = 3'd5,
    SEC_Q3_BPOS = 3'd6,
    SEC_Q3_BNEG = 3'd7
  } sector_t;

  // Stage enables from the controller to the datapath
  typedef struct packed {
    logic mul_en;
    logic ang_en;
    logic tab_en;
    logic vab_en;
    logic abc_en;
    logic expr_en;
    logic out_en;
  } svpwm_cmd_t;

  // Quarter-wave sine, Q16, one entry per whole degree
  function automatic logic [TRIG_W-1:0] sine_q16(input logic [IDX_W-1:0] idx);
    logic [TRIG_W-1:0] s;
    case (idx)
      7'd0:  s = 17'd0;
      7'd1:  s = 17'd1147;
      7'd2:  s = 17'd2287;
      7'd3:  s = 17'd3428;
      7'd4:  s = 17'd4574;
      7'd5:  s = 17'd5715;
      7'd6:  s = 17'd6849;
      7'd7:  s = 17'd7989;
      7'd8:  s = 17'd9123;
      7'd9:  s = 17'd10250;
      7'd10: s = 17'd11377;
      7'd11: s = 17'd12504;
      7'd12: s = 17'd13625;
      7'd13: s = 17'd14746;
      7'd14: s = 17'd15853;
      7'd15: s = 17'd16961;
      7'd16: s = 17'd18062;
      7'd17: s = 17'd19163;
      7'd18: s = 17'd20251;
      7'd19: s = 17'd21339;
      7'd20: s = 17'd22413;
      7'd21: s = 17'd23488;
      7'd22: s = 17'd24550;
      7'd23: s = 17'd25605;
      7'd24: s = 17'd26653;
      7'd25: s = 17'd27696;
      7'd26: s = 17'd28731;
      7'd27: s = 17'd29753;
      7'd28: s = 17'd30769;
      7'd29: s = 17'd31772;
      7'd30: s = 17'd32768;
      7'd31: s = 17'd33751;
      7'd32: s = 17'd34728;
      7'd33: s = 17'd35691;
      7'd34: s = 17'd36648;
      7'd35: s = 17'd37591;
      7'd36: s = 17'd38522;
      7'd37: s = 17'd39440;
      7'd38: s = 17'd40351;
      7'd39: s = 17'd41242;
      7'd40: s = 17'd42127;
      7'd41: s = 17'd42998;
      7'd42: s = 17'd43850;
      7'd43: s = 17'd44696;
      7'd44: s = 17'd45528;
      7'd45: s = 17'd46341;
      7'd46: s = 17'd47140;
      7'd47: s = 17'd47933;
      7'd48: s = 17'd48700;
      7'd49: s = 17'd49460;
      7'd50: s = 17'd50201;
      7'd51: s = 17'd50928;
      7'd52: s = 17'd51642;
      7'd53: s = 17'd52337;
      7'd54: s = 17'd53019;
      7'd55: s = 17'd53687;
      7'd56: s = 17'd54329;
      7'd57: s = 17'd54965;
      7'd58: s = 17'd55575;
      7'd59: s = 17'd56177;
      7'd60: s = 17'd56754;
      7'd61: s = 17'd57318;
      7'd62: s = 17'd57862;
      7'd63: s = 17'd58393;
      7'd64: s = 17'd58904;
      7'd65: s = 17'd59395;
      7'd66: s = 17'd59867;
      7'd67: s = 17'd60326;
      7'd68: s = 17'd60765;
      7'd69: s = 17'd61184;
      7'd70: s = 17'd61584;
      7'd71: s = 17'd61964;
      7'd72: s = 17'd62331;
      7'd73: s = 17'd62672;
      7'd74: s = 17'd63000;
      7'd75: s = 17'd63301;
      7'd76: s = 17'd63590;
      7'd77: s = 17'd63858;
      7'd78: s = 17'd64101;
      7'd79: s = 17'd64330;
      7'd80: s = 17'd64540;
      7'd81: s = 17'd64730;
      7'd82: s = 17'd64900;
      7'd83: s = 17'd65044;
      7'd84: s = 17'd65176;
      7'd85: s = 17'd65287;
      7'd86: s = 17'd65379;
      7'd87: s = 17'd65444;
      7'd88: s = 17'd65497;
      7'd89: s = 17'd65523;
      default: s = Q16_ONE;
    endcase
    return s;
  endfunction

endpackage

[rtl/svpwm_angle_duty_generator.sv]
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// cfg      cfg_valid / cfg_ready  cfg_index (0 gain, 1 offset, 2 step, 3 period), cfg_data
// in       in_valid / in_ready    speed
// out      out_valid / out_ready  duty_a, duty_b, duty_c, sector_code, angle_degree
//
// One speed beat passes through accept, then six steps of the controller
// (angle, table, voltage, scale, expression, duty). A result lands in the output
// register in the duty step, and the next beat is taken only after that, in the idle
// state, while that result may still wait downstream.
// A stalled output holds the block in its duty step. Configuration is always ready.
// Reset clears the configuration registers and the electrical angle to zero.
module svpwm_angle_duty_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [svpwm_pkg::SPEED_W-1:0]   speed,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_a,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_b,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_c,
  output logic [svpwm_pkg::CODE_W-1:0]           sector_code,
  output logic [svpwm_pkg::DEG_W-1:0]            angle_degree
);
  import svpwm_pkg::*;

  svpwm_cmd_t cmd;
  logic       cfg_we;

  // Take configuration beats at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  svpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  svpwm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .speed        (speed),
    .duty_a       (duty_a),
    .duty_b       (duty_b),
    .duty_c       (duty_c),
    .sector_code  (sector_code),
    .angle_degree (angle_degree)
  );

endmodule

[rtl/svpwm_ctrl.sv]
`timescale 1ns / 1ps
module svpwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output svpwm_pkg::svpwm_cmd_t cmd
);
  import svpwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_TABLE,
    S_VOLT,
    S_SCALE,
    S_EXPR,
    S_DUTY
  } state_t;

  state_t state;

  // Decode stage enables from the current state
  always_comb begin
    cmd         = '0;
    cmd.mul_en  = (state == S_IDLE) && in_valid;
    cmd.ang_en  = (state == S_ANGLE);
    cmd.tab_en  = (state == S_TABLE);
    cmd.vab_en  = (state == S_VOLT);
    cmd.abc_en  = (state == S_SCALE);
    cmd.expr_en = (state == S_EXPR);
    cmd.out_en  = (state == S_DUTY) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  // Advance through the steps; hold in the duty step until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_ANGLE;
        S_ANGLE: state <= S_TABLE;
        S_TABLE: state <= S_VOLT;
        S_VOLT:  state <= S_SCALE;
        S_SCALE: state <= S_EXPR;
        S_EXPR:  state <= S_DUTY;
        S_DUTY:  if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cmd.out_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/svpwm_datapath.sv]
`timescale 1ns / 1ps
module svpwm_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  svpwm_pkg::svpwm_cmd_t                  cmd,
  input  logic                                   cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [svpwm_pkg::SPEED_W-1:0]   speed,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_a,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_b,
  output logic [svpwm_pkg::DUTY_W-1:0]           duty_c,
  output logic [svpwm_pkg::CODE_W-1:0]           sector_code,
  output logic [svpwm_pkg::DEG_W-1:0]            angle_degree
);
  import svpwm_pkg::*;

  localparam int GPROD_W = SPEED_W + GAIN_W;
  localparam int MSUM_W  = GPROD_W + 2;
  localparam int SPROD_W = SPEED_W + STEP_W;
  localparam int ASUM_W  = ANGLE_W + 2;
  localparam int EXPR_W  = 21;
  localparam int X_W     = 19;

  // Configuration registers
  logic signed [GAIN_W-1:0]   mod_gain;
  logic signed [OFFSET_W-1:0] mod_offset;
  logic [STEP_W-1:0]          angle_step;
  logic [PERIOD_W-1:0]        pwm_period;

  // Angle state
  logic [ANGLE_W-1:0] angle, angle_next;

  // Stage registers
  logic signed [GPROD_W-1:0] gain_prod, gain_prod_next;
  logic [SPROD_W-1:0]        step_prod, step_prod_next;
  logic [SPEED_W-1:0]        speed_mag;
  logic                      speed_neg;
  logic [TRIG_W-1:0]         v_mag, v_next;
  logic [DEG_W-1:0]          deg, deg_next;
  logic [TRIG_W-1:0]         sin_mag, cos_mag;
  logic                      sin_neg, cos_neg, sin_neg_next, cos_neg_next;
  logic [IDX_W-1:0]          sin_idx, cos_idx;
  logic [TRIG_W-1:0]         va_mag, vb_mag, va_next, vb_next;
  logic                      va_neg, vb_neg;
  logic [TRIG_W-1:0]         ava;
  logic [15:0]               k1_term, k1_next;
  logic [16:0]               c_term, c_next;
  logic                      va_neg_q, vb_neg_q;
  logic [X_W-1:0]            x_a, x_b, x_c, x_a_next, x_b_next, x_c_next;
  logic [CODE_W-1:0]         code, code_next;

  // Intermediate values
  logic signed [MSUM_W-1:0] mod_sum;
  logic [MSUM_W-1:0]        mod_abs;
  logic [SPROD_W-9:0]       step_shr;
  logic [ANGLE_W-1:0]       step_sat;
  logic [ASUM_W-1:0]        angle_sum;
  logic [DEG_W-1:0]         sin_off, cos_off;
  logic [2*TRIG_W-1:0]      va_prod, vb_prod;
  logic [32:0]              k1_prod;
  logic [33:0]              k2_prod;
  logic signed [EXPR_W-1:0] a_val, b_val, c_val, e_a, e_b, e_c;
  logic [PERIOD_W+X_W-1:0]  pa_prod, pb_prod, pc_prod;
  logic [DUTY_W-1:0]        duty_cap;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_gain   <= '0;
      mod_offset <= '0;
      angle_step <= '0;
      pwm_period <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MOD_GAIN:   mod_gain   <= cfg_data[GAIN_W-1:0];
        CFG_MOD_OFFSET: mod_offset <= cfg_data[OFFSET_W-1:0];
        CFG_ANGLE_STEP: angle_step <= cfg_data[STEP_W-1:0];
        CFG_PWM_PERIOD: pwm_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Products of speed with gain and with step, taken straight from the input beat
  always_comb begin
    speed_mag      = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);
    gain_prod_next = GPROD_W'(speed) * GPROD_W'(mod_gain);
    step_prod_next = SPROD_W'(speed_mag) * SPROD_W'(angle_step);
  end

  // Modulation magnitude and angle advance
  always_comb begin
    mod_sum  = MSUM_W'(gain_prod) + (MSUM_W'(mod_offset) <<< 8);
    mod_abs  = mod_sum[MSUM_W-1] ? MSUM_W'(-mod_sum) : MSUM_W'(mod_sum);
    v_next   = (mod_abs[MSUM_W-1:8] > (MSUM_W-8)'(Q16_ONE)) ? Q16_ONE
                                                            : mod_abs[TRIG_W+7:8];
    step_shr = step_prod[SPROD_W-1:8];
    step_sat = (step_shr > (SPROD_W-8)'(ANGLE_MAX)) ? ANGLE_MAX : step_shr[ANGLE_W-1:0];
    angle_sum = speed_neg ? (ASUM_W'(angle) - ASUM_W'(step_sat))
                          : (ASUM_W'(angle) + ASUM_W'(step_sat));
    if (angle_sum[ASUM_W-1]) begin
      angle_next = ANGLE_W'(angle_sum + ASUM_W'(FULL_TURN));
    end else if (angle_sum >= ASUM_W'(FULL_TURN)) begin
      angle_next = ANGLE_W'(angle_sum - ASUM_W'(FULL_TURN));
    end else begin
      angle_next = angle_sum[ANGLE_W-1:0];
    end
  end

  // Fold the whole-degree angle into the quarter table for sine and cosine
  always_comb begin
    deg_next = angle[ANGLE_W-1:16];
    if (deg_next < 9'd91) begin
      sin_off = deg_next;          sin_neg_next = 1'b0;
      cos_off = 9'd90 - deg_next;  cos_neg_next = 1'b0;
    end else if (deg_next < 9'd181) begin
      sin_off = 9'd180 - deg_next; sin_neg_next = 1'b0;
      cos_off = deg_next - 9'd90;  cos_neg_next = 1'b1;
    end else if (deg_next < 9'd271) begin
      sin_off = deg_next - 9'd180; sin_neg_next = 1'b1;
      cos_off = 9'd270 - deg_next; cos_neg_next = 1'b1;
    end else begin
      sin_off = 9'd360 - deg_next; sin_neg_next = 1'b1;
      cos_off = deg_next - 9'd270; cos_neg_next = 1'b0;
    end
    sin_idx = sin_off[IDX_W-1:0];
    cos_idx = cos_off[IDX_W-1:0];
  end

  // Stationary-frame voltage magnitudes
  always_comb begin
    va_prod = (2*TRIG_W)'(v_mag) * (2*TRIG_W)'(cos_mag);
    vb_prod = (2*TRIG_W)'(v_mag) * (2*TRIG_W)'(sin_mag);
    va_next = va_prod[TRIG_W+15:16];
    vb_next = vb_prod[TRIG_W+15:16];
  end

  // Scale |Vb| by 1/sqrt(3) and 2/sqrt(3)
  always_comb begin
    k1_prod = 33'(K_HALF_INV_SQRT3) * 33'(vb_mag);
    k2_prod = 34'(K_TWO_INV_SQRT3) * 34'(vb_mag);
    k1_next = k1_prod[31:16];
    c_next  = k2_prod[32:16];
  end

  // Sector code and the three duty expressions, offset by one and floored at zero
  always_comb begin
    a_val = $signed(EXPR_W'(ava)) + $signed(EXPR_W'(k1_term));
    b_val = $signed(EXPR_W'(ava)) - $signed(EXPR_W'(k1_term));
    c_val = $signed(EXPR_W'(c_term));
    code_next = {vb_neg_q, va_neg_q, b_val[EXPR_W-1]};
    case (sector_t'(code_next))
      SEC_Q1_BPOS: begin
        e_a = a_val;                  e_b = (c_val <<< 1) - a_val; e_c = -a_val;
      end
      SEC_Q1_BNEG: begin
        e_a = (b_val <<< 1) + c_val;  e_b = c_val;                 e_c = -c_val;
      end
      SEC_Q2_BPOS: begin
        e_a = -a_val;                 e_b = a_val;                 e_c = a_val - (c_val <<< 1);
      end
      SEC_Q2_BNEG: begin
        e_a = c_val - (a_val <<< 1);  e_b = c_val;                 e_c = -c_val;
      end
      SEC_Q4_BPOS: begin
        e_a = a_val;                  e_b = -a_val;                e_c = (c_val <<< 1) - a_val;
      end
      SEC_Q4_BNEG: begin
        e_a = (b_val <<< 1) + c_val;  e_b = -c_val;                e_c = c_val;
      end
      SEC_Q3_BPOS: begin
        e_a = -a_val;                 e_b = a_val - (c_val <<< 1); e_c = a_val;
      end
      default: begin
        e_a = c_val - (a_val <<< 1);  e_b = -c_val;                e_c = c_val;
      end
    endcase
    e_a = e_a + EXPR_W'(65536);
    e_b = e_b + EXPR_W'(65536);
    e_c = e_c + EXPR_W'(65536);
    x_a_next = e_a[EXPR_W-1] ? '0 : e_a[X_W-1:0];
    x_b_next = e_b[EXPR_W-1] ? '0 : e_b[X_W-1:0];
    x_c_next = e_c[EXPR_W-1] ? '0 : e_c[X_W-1:0];
  end

  // Scale by the period and clamp to twice the period
  always_comb begin
    duty_cap = {pwm_period, 1'b0};
    pa_prod  = (PERIOD_W+X_W)'(pwm_period) * (PERIOD_W+X_W)'(x_a);
    pb_prod  = (PERIOD_W+X_W)'(pwm_period) * (PERIOD_W+X_W)'(x_b);
    pc_prod  = (PERIOD_W+X_W)'(pwm_period) * (PERIOD_W+X_W)'(x_c);
  end

  // Angle state, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
    end else if (cmd.ang_en) begin
      angle <= angle_next;
    end
  end

  // Step registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      gain_prod <= gain_prod_next;
      step_prod <= step_prod_next;
      speed_neg <= speed[SPEED_W-1];
    end
    if (cmd.ang_en) begin
      v_mag <= v_next;
    end
    if (cmd.tab_en) begin
      deg     <= deg_next;
      sin_mag <= sine_q16(sin_idx);
      cos_mag <= sine_q16(cos_idx);
      sin_neg <= sin_neg_next;
      cos_neg <= cos_neg_next;
    end
    if (cmd.vab_en) begin
      va_mag <= va_next;
      vb_mag <= vb_next;
      va_neg <= cos_neg;
      vb_neg <= sin_neg;
    end
    if (cmd.abc_en) begin
      ava      <= va_mag;
      k1_term  <= k1_next;
      c_term   <= c_next;
      // a voltage that truncates to zero counts as not negative
      va_neg_q <= va_neg && (va_mag != '0);
      vb_neg_q <= vb_neg && (vb_mag != '0);
    end
    if (cmd.expr_en) begin
      x_a  <= x_a_next;
      x_b  <= x_b_next;
      x_c  <= x_c_next;
      code <= code_next;
    end
    if (cmd.out_en) begin
      duty_a <= (pa_prod[PERIOD_W+X_W-1:16] > X_W'(duty_cap)) ? duty_cap
                                                               : pa_prod[DUTY_W+15:16];
      duty_b <= (pb_prod[PERIOD_W+X_W-1:16] > X_W'(duty_cap)) ? duty_cap
                                                               : pb_prod[DUTY_W+15:16];
      duty_c <= (pc_prod[PERIOD_W+X_W-1:16] > X_W'(duty_cap)) ? duty_cap
                                                               : pc_prod[DUTY_W+15:16];
      sector_code  <= code;
      angle_degree <= deg;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import svpwm_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    sector_t           sector;
    logic [DEG_W-1:0]  deg;
  } pwm_result_t;

  localparam longint TURN_Q16    = 360 * 65536;
  localparam longint HALF_ISQRT3 = 37840;
  localparam longint TWO_ISQRT3  = 75673;
  localparam int     LONG_HOLD   = 300;

  // Sine of whole degrees to four decimals, scaled by 10000
  int sine_e4 [SINE_ENTRIES] = '{
    0, 175, 349, 523, 698, 872, 1045, 1219, 1392, 1564, 1736,
    1908, 2079, 2250, 2419, 2588, 2756, 2924, 3090, 3256, 3420,
    3584, 3746, 3907, 4067, 4226, 4384, 4540, 4695, 4848, 5000,
    5150, 5299, 5446, 5592, 5736, 5878, 6018, 6157, 6293, 6428,
    6561, 6691, 6820, 6947, 7071, 7193, 7314, 7431, 7547, 7660,
    7771, 7880, 7986, 8090, 8192, 8290, 8387, 8480, 8572, 8660,
    8746, 8829, 8910, 8988, 9063, 9135, 9205, 9272, 9336, 9397,
    9455, 9511, 9563, 9613, 9659, 9703, 9744, 9781, 9816, 9848,
    9877, 9903, 9925, 9945, 9962, 9976, 9986, 9994, 9998, 10000
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SPEED_W-1:0] speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] duty_a, duty_b, duty_c;
  logic [CODE_W-1:0] sector_code;
  logic [DEG_W-1:0] angle_degree;

  // Bench copy of the registers and the electrical angle
  longint gain_q = 0;
  longint offset_q = 0;
  longint step_q = 0;
  longint period_q = 0;
  longint track_angle = 0;

  pwm_result_t pending_duties [$];
  int fail_count = 0;
  int beats_taken = 0;
  int reg_writes = 0;
  int phase_count = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit rx_hold_req = 1'b0;

  svpwm_angle_duty_generator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .speed        (speed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_a       (duty_a),
    .duty_b       (duty_b),
    .duty_c       (duty_c),
    .sector_code  (sector_code),
    .angle_degree (angle_degree)
  );

  always #5 clk = ~clk;

  // Quarter-wave entry in Q16, rounded from the four-decimal value
  function automatic longint quarter_sine(input int k);
    int idx;
    idx = (k < 0) ? 0 : ((k > SINE_ENTRIES - 1) ? SINE_ENTRIES - 1 : k);
    return (longint'(sine_e4[idx]) * 65536 + 5000) / 10000;
  endfunction

  function automatic longint trig_sin(input int deg);
    if (deg < 91) return quarter_sine(deg);
    if (deg < 181) return quarter_sine(180 - deg);
    if (deg < 271) return -quarter_sine(deg - 180);
    return -quarter_sine(360 - deg);
  endfunction

  function automatic longint trig_cos(input int deg);
    if (deg < 91) return quarter_sine(90 - deg);
    if (deg < 181) return -quarter_sine(deg - 90);
    if (deg < 271) return -quarter_sine(270 - deg);
    return quarter_sine(deg - 270);
  endfunction

  // Magnitude product, truncated, then the sign of the trig value
  function automatic longint scale_by_trig(input longint v, input longint t);
    longint mag;
    mag = (v * ((t < 0) ? -t : t)) >>> 16;
    return (t < 0) ? -mag : mag;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_from_expr(input longint e);
    longint x, dd;
    x = 65536 + e;
    if (x < 0) x = 0;
    dd = (period_q * x) >>> 16;
    if (dd > 2 * period_q) dd = 2 * period_q;
    return dd[DUTY_W-1:0];
  endfunction

  // Advance the bench angle and work out the compare values for one tick
  function automatic pwm_result_t predict_tick(input logic signed [SPEED_W-1:0] spd);
    longint s, m, v, d, va, vb, ava, avb, a, b, c, xa, xb, xc;
    int deg;
    logic [CODE_W-1:0] code_bits;
    pwm_result_t r;
    s = spd;
    m = s * gain_q + offset_q * 256;
    if (m < 0) m = -m;
    v = m >>> 8;
    if (v > 65536) v = 65536;

    d = (((s < 0) ? -s : s) * step_q) >>> 8;
    if (d > TURN_Q16 - 1) d = TURN_Q16 - 1;
    if (s < 0) d = -d;
    track_angle = track_angle + d;
    if (track_angle >= TURN_Q16) track_angle = track_angle - TURN_Q16;
    if (track_angle < 0) track_angle = track_angle + TURN_Q16;
    deg = int'(track_angle >>> 16);

    va = scale_by_trig(v, trig_cos(deg));
    vb = scale_by_trig(v, trig_sin(deg));
    ava = (va < 0) ? -va : va;
    avb = (vb < 0) ? -vb : vb;
    a = ava + ((HALF_ISQRT3 * avb) >>> 16);
    b = ava - ((HALF_ISQRT3 * avb) >>> 16);
    c = (TWO_ISQRT3 * avb) >>> 16;
    code_bits = {vb < 0, va < 0, b < 0};

    case (sector_t'(code_bits))
      SEC_Q1_BPOS: begin xa = a;          xb = -a + 2 * c; xc = -a;         end
      SEC_Q1_BNEG: begin xa = 2 * b + c;  xb = c;          xc = -c;         end
      SEC_Q2_BPOS: begin xa = -a;         xb = a;          xc = a - 2 * c;  end
      SEC_Q2_BNEG: begin xa = -2 * a + c; xb = c;          xc = -c;         end
      SEC_Q4_BPOS: begin xa = a;          xb = -a;         xc = -a + 2 * c; end
      SEC_Q4_BNEG: begin xa = 2 * b + c;  xb = -c;         xc = c;          end
      SEC_Q3_BPOS: begin xa = -a;         xb = a - 2 * c;  xc = a;          end
      default:     begin xa = -2 * a + c; xb = -c;         xc = c;          end
    endcase
    r.duty_a = duty_from_expr(xa);
    r.duty_b = duty_from_expr(xb);
    r.duty_c = duty_from_expr(xc);
    r.sector = sector_t'(code_bits);
    r.deg = deg[DEG_W-1:0];
    return r;
  endfunction

  // Predict on every accepted speed beat, check every accepted result beat
  always @(posedge clk) begin : result_checker
    pwm_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_duties.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_duties.pop_front();
          if (duty_a !== want.duty_a) begin
            $error("duty_a expected %0d actual %0d", want.duty_a, duty_a);
            fail_count++;
          end
          if (duty_b !== want.duty_b) begin
            $error("duty_b expected %0d actual %0d", want.duty_b, duty_b);
            fail_count++;
          end
          if (duty_c !== want.duty_c) begin
            $error("duty_c expected %0d actual %0d", want.duty_c, duty_c);
            fail_count++;
          end
          if (sector_code !== want.sector) begin
            $error("sector_code expected %0d actual %0d", want.sector, sector_code);
            fail_count++;
          end
          if (angle_degree !== want.deg) begin
            $error("angle_degree expected %0d actual %0d", want.deg, angle_degree);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_duties.push_back(predict_tick(speed));
        beats_taken++;
      end
    end
  end

  // Receiver: stall before each result, or hold off for a long stretch on request
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 19) : 0;
      if (rx_hold_req) begin
        stall = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one speed beat after a random gap and hold it until accepted
  task automatic send_speed(input logic signed [SPEED_W-1:0] spd);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    speed <= spd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait for every expected result, then let the pipe empty
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MOD_GAIN:   gain_q = longint'($signed(data));
      CFG_MOD_OFFSET: offset_q = longint'($signed(data[OFFSET_W-1:0]));
      CFG_ANGLE_STEP: step_q = longint'(data[STEP_W-1:0]);
      default:        period_q = longint'(data[PERIOD_W-1:0]);
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] gain, input logic [31:0] offs,
                           input logic [31:0] step, input logic [31:0] period);
    write_reg(CFG_MOD_GAIN, gain);
    write_reg(CFG_MOD_OFFSET, offs);
    write_reg(CFG_ANGLE_STEP, step);
    write_reg(CFG_PWM_PERIOD, period);
    phase_count++;
  endtask

  // Registers at reset: no modulation, no motion, zero period
  task automatic test_reset_defaults();
    send_speed(16'sd0);
    send_speed(16'sd32767);
    send_speed(-16'sd32768);
    settle_block();
  endtask

  // Extreme gains saturate the modulation, full-scale speeds and period
  task automatic test_gain_extremes();
    write_all(32'h7FFF_FFFF, 32'd0, 32'd1000, 32'd65535);
    send_speed(16'sd32767);
    send_speed(-16'sd32768);
    send_speed(16'sd1);
    send_speed(-16'sd1);
    settle_block();
    write_reg(CFG_MOD_GAIN, 32'h8000_0000);
    send_speed(16'sd32767);
    send_speed(16'sd0);
    settle_block();
  endtask

  // Offsets of one and beyond in both signs, taken as the signed 18-bit field
  task automatic test_offset_range();
    write_all(32'd0, 32'h0001_FFFF, 32'd0, 32'd40000);
    send_speed(16'sd5);
    settle_block();
    write_reg(CFG_MOD_OFFSET, 32'h0002_0000);
    send_speed(-16'sd5);
    settle_block();
    write_reg(CFG_MOD_OFFSET, 32'h0001_0000);
    send_speed(16'sd0);
    settle_block();
    write_reg(CFG_MOD_OFFSET, 32'h0003_0000);
    send_speed(16'sd0);
    settle_block();
  endtask

  // Full modulation swept round the turn: every sector, negative and clamped duties
  task automatic test_sector_sweep();
    write_all(32'd0, 32'h0001_0000, 32'd620756, 32'd50000);
    for (int k = 0; k < 10; k++) send_speed(16'sd1000);
    send_speed(-16'sd1000);
    send_speed(-16'sd1700);
    settle_block();
  endtask

  // Largest step saturates just below a full turn, both directions
  task automatic test_step_saturation();
    write_all(32'd100, 32'd0, 32'h00FF_FFFF, 32'd1);
    send_speed(16'sd32767);
    send_speed(-16'sd32768);
    send_speed(16'sd1);
    settle_block();
  endtask

  // Unit modulation: voltages truncate to zero and count as not negative
  task automatic test_zero_voltage();
    write_all(32'd0, 32'd1, 32'd1500000, 32'd65535);
    send_speed(16'sd300);
    send_speed(16'sd300);
    send_speed(-16'sd700);
    settle_block();
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    write_all(32'd700, 32'h3_F000, 32'd30000, 32'd20000);
    tx_gaps_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int k = 0; k < 40; k++) send_speed(16'($urandom_range(0, 65535)));
    settle_block();
    tx_gaps_on = 1'b1;
  endtask

  // Random configurations, extremes first, each with a run of random speeds
  task automatic test_random_phases();
    logic [31:0] gain, offs, step, period;
    logic signed [SPEED_W-1:0] spd;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        gain = 32'h8000_0000;
        offs = 32'h0002_0000;
        step = 32'd0;
        period = 32'd0;
      end else if (ph == 1) begin
        gain = 32'h7FFF_FFFF;
        offs = 32'hFFFD_FFFF;
        step = 32'hFFFF_FFFF;
        period = 32'hFFFF_FFFF;
      end else begin
        case ($urandom_range(0, 2))
          0:       gain = $urandom;
          1:       gain = $urandom_range(0, 2047) - 1024;
          default: gain = $urandom_range(0, 2097152) - 1048576;
        endcase
        offs = $urandom_range(0, 1) ? $urandom
                                    : {14'($urandom_range(0, 16383)),
                                       18'(131072 - $urandom_range(0, 131072) - 65536)};
        step = $urandom_range(0, 1) ? $urandom
                                    : {8'($urandom_range(0, 255)),
                                       24'($urandom_range(0, 200000))};
        period = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      end
      write_all(gain, offs, step, period);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 97; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: spd = 16'($urandom_range(0, 65535));
          5, 6, 7:       spd = 16'($urandom_range(0, 4000) - 2000);
          8:             spd = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
          default:       spd = 16'($urandom_range(0, 2) - 1);
        endcase
        send_speed(spd);
      end
      settle_block();
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_gain_extremes();
    test_offset_range();
    test_sector_sweep();
    test_step_saturation();
    test_zero_voltage();
    test_output_backpressure();
    test_random_phases();
    settle_block();
    repeat (10) @(posedge clk);
    $display("Run covered %0d speed beats over %0d register settings (%0d writes),",
             beats_taken, phase_count, reg_writes);
    $display("with directed sector, saturation and backpressure cases; %0d mismatches.",
             fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
